>>> rtl/c3f_pkg.sv
// Shared types and constants of the 3x3 convolution filter.
package c3f_pkg;

   localparam int FRAC_BITS       = 12;
   localparam int PIX_MAX         = 255;
   localparam int KERNEL_SIZE     = 3;
   localparam int ROUND_HALF      = 1 << (FRAC_BITS - 1);
   localparam int COEF_ROW_WIDTH  = 60;
   localparam int IMG_WIDTH_BITS  = 11;
   localparam int IMG_HEIGHT_BITS = 16;
   localparam int OUT_COL_BITS    = 10;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = COEF_ROW_WIDTH;
   localparam int RESULT_SLOTS    = 4;

   localparam logic [COEF_ROW_WIDTH-1:0]  COEF_TOP_RESET    = '0;
   localparam logic [COEF_ROW_WIDTH-1:0]  COEF_MID_RESET    = 60'h0_0001_0000_0000;
   localparam logic [COEF_ROW_WIDTH-1:0]  COEF_BOTTOM_RESET = '0;
   localparam logic [IMG_WIDTH_BITS-1:0]  IMG_WIDTH_RESET   = 11'd640;
   localparam logic [IMG_HEIGHT_BITS-1:0] IMG_HEIGHT_RESET  = 16'd480;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COEF_TOP     = 3'd0,
      CSR_COEF_MID     = 3'd1,
      CSR_COEF_BOTTOM  = 3'd2,
      CSR_IMAGE_WIDTH  = 3'd3,
      CSR_IMAGE_HEIGHT = 3'd4
   } csr_index_type;

   typedef logic [7:0] pix_type;

   typedef struct packed {
      logic [OUT_COL_BITS-1:0]    column;
      logic [IMG_HEIGHT_BITS-1:0] row;
      logic                       run_last;
      logic                       frame_end;
   } meta_type;

   typedef struct packed {
      pix_type [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] taps;
      meta_type                                   meta;
   } tap_set_type;

endpackage

>>> rtl/c3f_if.sv
// Request and response channel interfaces of the convolution filter.
interface c3f_req_if import c3f_pkg::*; ();
   logic    valid;
   logic    ready;
   pix_type pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface c3f_rsp_if import c3f_pkg::*; ();
   logic                       valid;
   logic                       ready;
   pix_type                    pixel_out;
   logic [OUT_COL_BITS-1:0]    out_column;
   logic [IMG_HEIGHT_BITS-1:0] out_row;
   logic                       run_last;
   logic                       frame_end;

   modport source (output valid, output pixel_out, output out_column, output out_row,
                   output run_last, output frame_end, input ready);
   modport sink   (input valid, input pixel_out, input out_column, input out_row,
                   input run_last, input frame_end, output ready);
endinterface

>>> rtl/c3f_ram.sv
// Generic single-write, single-read RAM with registered read data.
module c3f_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/c3f_window.sv
// Position counters, line store, 3x3 window and per-pixel result sequencer.
module c3f_window import c3f_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   localparam int AW = $clog2(MAX_WIDTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   c3f_req_if.sink                    req_bus,
   input  logic [AW-1:0]              col_lim,
   input  logic [IMG_HEIGHT_BITS-1:0] row_lim,
   output logic                       iss_valid,
   input  logic                       iss_ready,
   output tap_set_type                iss_data
);

   localparam int LW = 16;

   // position of the next pixel
   logic [AW-1:0]              col_ff, col_in;
   logic [IMG_HEIGHT_BITS-1:0] row_ff, row_in;
   logic                       accept, col_last, row_last;

   // stage 1: pixel waiting for its line store word
   logic                       s1_valid_ff, s1_valid_in;
   pix_type                    s1_pix_ff;
   logic [AW-1:0]              s1_col_ff;
   logic [IMG_HEIGHT_BITS-1:0] s1_row_ff;
   logic                       s1_col_last_ff, s1_row_last_ff;
   logic                       s1_byp_ff;
   logic [LW-1:0]              s1_byp_data_ff;
   logic                       s1_adv;
   logic [LW-1:0]              rd_data, line_eff, wr_data;
   logic [RESULT_SLOTS-1:0]    new_mask;

   // stage 2: window and pending results
   pix_type                    win_ff [KERNEL_SIZE][KERNEL_SIZE];
   logic [AW-1:0]              s2_col_ff;
   logic [IMG_HEIGHT_BITS-1:0] s2_row_ff;
   logic                       s2_c_ge1_ff, s2_c_ge2_ff, s2_r_ge1_ff, s2_r_ge2_ff;
   logic [RESULT_SLOTS-1:0]    pend_ff, pend_in;
   logic [RESULT_SLOTS-1:0]    sel_oh, pend_left;
   logic [1:0]                 sel_j;
   logic                       iss_fire, s2_done;
   logic [2:0]                 tap_wr, tap_wc;
   logic                       tap_ok;
   logic [AW-1:0]              col_out;
   logic [IMG_HEIGHT_BITS-1:0] row_out;

   assign col_last = col_ff >= col_lim;
   assign row_last = row_ff >= row_lim;

   // lowest pending result goes first: raster order of the outputs
   assign sel_oh    = pend_ff & (~pend_ff + 4'd1);
   assign pend_left = pend_ff & ~sel_oh;

   always_comb begin
      sel_j = 2'd0;
      if (pend_ff[0]) begin
         sel_j = 2'd0;
      end else if (pend_ff[1]) begin
         sel_j = 2'd1;
      end else if (pend_ff[2]) begin
         sel_j = 2'd2;
      end else begin
         sel_j = 2'd3;
      end
   end

   assign iss_valid     = pend_ff != '0;
   assign iss_fire      = iss_valid && iss_ready;
   assign s2_done       = (pend_ff == '0) || (iss_fire && (pend_left == '0));
   assign s1_adv        = s1_valid_ff && s2_done;
   assign req_bus.ready = !s1_valid_ff || s2_done;
   assign accept        = req_bus.valid && req_bus.ready;

   // upper row in the high byte, lower row in the low byte
   assign line_eff = s1_byp_ff ? s1_byp_data_ff : rd_data;
   assign wr_data  = {line_eff[7:0], s1_pix_ff};

   c3f_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   assign new_mask = {s1_row_last_ff && s1_col_last_ff,
                      s1_row_last_ff && (s1_col_ff != '0),
                      (s1_row_ff != '0) && s1_col_last_ff,
                      (s1_row_ff != '0) && (s1_col_ff != '0)};

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = s1_valid_ff;
      pend_in     = pend_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (s1_adv) begin
         pend_in = new_mask;
      end else if (iss_fire) begin
         pend_in = pend_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         pend_ff     <= '0;
         for (int k = 0; k < KERNEL_SIZE; k++) begin
            for (int m = 0; m < KERNEL_SIZE; m++) begin
               win_ff[k][m] <= '0;
            end
         end
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         pend_ff     <= pend_in;
         if (s1_adv) begin
            for (int k = 0; k < KERNEL_SIZE; k++) begin
               win_ff[k][0] <= win_ff[k][1];
               win_ff[k][1] <= win_ff[k][2];
            end
            win_ff[0][2] <= line_eff[15:8];
            win_ff[1][2] <= line_eff[7:0];
            win_ff[2][2] <= s1_pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= req_bus.pixel_in;
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_col_last_ff <= col_last;
         s1_row_last_ff <= row_last;
         // one-column frames read the entry the leaving pixel writes now
         s1_byp_ff      <= s1_adv && (s1_col_ff == col_ff);
         s1_byp_data_ff <= wr_data;
      end
      if (s1_adv) begin
         s2_col_ff   <= s1_col_ff;
         s2_row_ff   <= s1_row_ff;
         s2_c_ge1_ff <= s1_col_ff != '0;
         s2_c_ge2_ff <= s1_col_ff >= AW'(2);
         s2_r_ge1_ff <= s1_row_ff != '0;
         s2_r_ge2_ff <= s1_row_ff >= 16'd2;
      end
   end

   assign col_out = s2_col_ff - {{(AW-1){1'b0}}, ~sel_j[0]};
   assign row_out = s2_row_ff - {{(IMG_HEIGHT_BITS-1){1'b0}}, ~sel_j[1]};

   // taps for the selected centre; outside the image or the window they read zero
   always_comb begin
      tap_wr = '0;
      tap_wc = '0;
      tap_ok = 1'b0;
      for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
         for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
            tap_wr = 3'(ky) + {2'b00, sel_j[1]};
            tap_wc = 3'(kx) + {2'b00, sel_j[0]};
            tap_ok = (tap_wr <= 3'd2) && (tap_wc <= 3'd2)
                     && !((tap_wr == 3'd0) && !s2_r_ge2_ff)
                     && !((tap_wr == 3'd1) && !s2_r_ge1_ff)
                     && !((tap_wc == 3'd0) && !s2_c_ge2_ff)
                     && !((tap_wc == 3'd1) && !s2_c_ge1_ff);
            iss_data.taps[ky][kx] = tap_ok ? win_ff[tap_wr[1:0]][tap_wc[1:0]] : '0;
         end
      end
      iss_data.meta.column    = OUT_COL_BITS'(col_out);
      iss_data.meta.row       = row_out;
      iss_data.meta.run_last  = pend_left == '0;
      iss_data.meta.frame_end = sel_j == 2'd3;
   end

endmodule

>>> rtl/c3f_mac.sv
// Multiply, sum, clamp and round pipeline with the output skid buffer.
module c3f_mac import c3f_pkg::*; #(
   parameter int COEF_WIDTH = 20
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic [KERNEL_SIZE-1:0][COEF_ROW_WIDTH-1:0] coef_rows,
   input  logic                                       iss_valid,
   output logic                                       iss_ready,
   input  tap_set_type                                iss_data,
   c3f_rsp_if.source                                  rsp_bus
);

   localparam int PW = COEF_WIDTH + 9;
   localparam int SW = PW + 2;
   localparam int TW = PW + 4;

   logic signed [COEF_WIDTH-1:0] cf [KERNEL_SIZE][KERNEL_SIZE];
   logic signed [PW-1:0]         pix_x, cf_x;
   logic signed [PW-1:0]         prod_in [KERNEL_SIZE][KERNEL_SIZE];
   logic signed [PW-1:0]         prod_ff [KERNEL_SIZE][KERNEL_SIZE];
   meta_type                     p_meta_ff;
   logic                         p_valid_ff;
   logic signed [SW-1:0]         sum_in [KERNEL_SIZE];
   logic signed [SW-1:0]         sum_ff [KERNEL_SIZE];
   meta_type                     q_meta_ff;
   logic                         q_valid_ff;
   logic signed [TW-1:0]         tot;
   pix_type                      res_pix;
   pix_type                      out_pix_ff, skid_pix_ff;
   meta_type                     out_meta_ff, skid_meta_ff;
   logic                         out_valid_ff, skid_valid_ff;
   logic                         out_room, q_ready, p_ready, q_take;

   assign out_room  = !skid_valid_ff;
   assign q_ready   = !q_valid_ff || out_room;
   assign p_ready   = !p_valid_ff || q_ready;
   assign iss_ready = p_ready;
   assign q_take    = q_valid_ff && out_room;

   always_comb begin
      pix_x = '0;
      cf_x  = '0;
      for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
         for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
            cf[ky][kx]      = coef_rows[ky][kx*COEF_WIDTH +: COEF_WIDTH];
            pix_x           = PW'({1'b0, iss_data.taps[ky][kx]});
            cf_x            = PW'(cf[ky][kx]);
            prod_in[ky][kx] = pix_x * cf_x;
         end
      end
   end

   // half an LSB of the result rides along in the middle row sum
   always_comb begin
      sum_in[0] = SW'(prod_ff[0][0]) + SW'(prod_ff[0][1]) + SW'(prod_ff[0][2]);
      sum_in[1] = SW'(prod_ff[1][0]) + SW'(prod_ff[1][1]) + SW'(prod_ff[1][2])
                  + SW'(ROUND_HALF);
      sum_in[2] = SW'(prod_ff[2][0]) + SW'(prod_ff[2][1]) + SW'(prod_ff[2][2]);
   end

   assign tot = TW'(sum_ff[0]) + TW'(sum_ff[1]) + TW'(sum_ff[2]);

   always_comb begin
      if (tot < TW'(ROUND_HALF)) begin
         res_pix = '0;
      end else if (tot > TW'((PIX_MAX << FRAC_BITS) + ROUND_HALF)) begin
         res_pix = pix_type'(PIX_MAX);
      end else begin
         res_pix = tot[FRAC_BITS +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff    <= 1'b0;
         q_valid_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (p_ready) begin
            p_valid_ff <= iss_valid;
         end
         if (q_ready) begin
            q_valid_ff <= p_valid_ff;
         end
         if (!out_valid_ff || rsp_bus.ready) begin
            out_valid_ff  <= skid_valid_ff || q_take;
            skid_valid_ff <= 1'b0;
         end else if (q_take) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_ready && iss_valid) begin
         prod_ff   <= prod_in;
         p_meta_ff <= iss_data.meta;
      end
      if (q_ready && p_valid_ff) begin
         sum_ff    <= sum_in;
         q_meta_ff <= p_meta_ff;
      end
      if (!out_valid_ff || rsp_bus.ready) begin
         out_pix_ff  <= skid_valid_ff ? skid_pix_ff : res_pix;
         out_meta_ff <= skid_valid_ff ? skid_meta_ff : q_meta_ff;
      end else if (q_take) begin
         skid_pix_ff  <= res_pix;
         skid_meta_ff <= q_meta_ff;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.pixel_out  = out_pix_ff;
   assign rsp_bus.out_column = out_meta_ff.column;
   assign rsp_bus.out_row    = out_meta_ff.row;
   assign rsp_bus.run_last   = out_meta_ff.run_last;
   assign rsp_bus.frame_end  = out_meta_ff.frame_end;

endmodule

>>> rtl/conv3x3_image_filter_top.sv
// Top level of the 3x3 zero-padded convolution filter for 8-bit grey frames.
//
//   channel   direction  handshake            word
//   req_bus   in         valid/ready          pixel_in, raster order
//   rsp_bus   out        valid/ready          pixel_out, out_column, out_row,
//                                             run_last, frame_end
//   csr_*     in         csr_we, no wait      csr_index, csr_wdata
//
// One pixel per clock is taken while each pixel yields at most one result and the
// output is not stalled; a pixel on the last column or the last row yields up to two
// words, the bottom-right pixel up to four, and each holds the input until its
// words are issued. The single result path (tap select, one multiply stage, row
// sums, final sum/clamp/round) moves one word per clock while rsp_bus takes them.
// A pixel's words pass the stage-1, window, product, row-sum and output registers.
// Reset: synchronous, clears counters, window and valids; the line store needs no
// clearing pass. Stalls: a 2-entry output skid keeps rsp_bus.ready off the input side.
module conv3x3_image_filter_top import c3f_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int COEF_WIDTH = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   c3f_req_if.sink                    req_bus,
   c3f_rsp_if.source                  rsp_bus,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = (AW + 1 > IMG_WIDTH_BITS) ? AW + 1 : IMG_WIDTH_BITS;

   logic [KERNEL_SIZE-1:0][COEF_ROW_WIDTH-1:0] coef_ff;
   logic [IMG_WIDTH_BITS-1:0]                  width_ff;
   logic [IMG_HEIGHT_BITS-1:0]                 height_ff;
   logic [WW-1:0]                              width_ext;
   logic [AW-1:0]                              col_lim;
   logic [IMG_HEIGHT_BITS-1:0]                 row_lim;
   logic                                       iss_valid, iss_ready;
   tap_set_type                                iss_data;

   // register file: write only; the user writes while the filter is idle, unenforced
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= COEF_TOP_RESET;
         coef_ff[1] <= COEF_MID_RESET;
         coef_ff[2] <= COEF_BOTTOM_RESET;
         width_ff   <= IMG_WIDTH_RESET;
         height_ff  <= IMG_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COEF_TOP:     coef_ff[0] <= csr_wdata;
            CSR_COEF_MID:     coef_ff[1] <= csr_wdata;
            CSR_COEF_BOTTOM:  coef_ff[2] <= csr_wdata;
            CSR_IMAGE_WIDTH:  width_ff   <= csr_wdata[IMG_WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff  <= csr_wdata[IMG_HEIGHT_BITS-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // last column: a width of zero acts as one, a width beyond the store as the store
   assign width_ext = WW'(width_ff);

   always_comb begin
      if (width_ff == '0) begin
         col_lim = '0;
      end else if (width_ext > WW'(MAX_WIDTH)) begin
         col_lim = AW'(MAX_WIDTH - 1);
      end else begin
         col_lim = AW'(width_ext - 1'b1);
      end
   end

   assign row_lim = (height_ff == '0) ? '0 : height_ff - 1'b1;

   c3f_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .col_lim   (col_lim),
      .row_lim   (row_lim),
      .iss_valid (iss_valid),
      .iss_ready (iss_ready),
      .iss_data  (iss_data)
   );

   c3f_mac #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .coef_rows (coef_ff),
      .iss_valid (iss_valid),
      .iss_ready (iss_ready),
      .iss_data  (iss_data),
      .rsp_bus   (rsp_bus)
   );

endmodule

>>> bench/conv3x3_image_filter_top_tb.sv
// Self-checking bench for the 3x3 convolution filter: directed frames, a wide single-row frame, then random frames.
`timescale 1ns / 100ps

module conv3x3_image_filter_top_tb import c3f_pkg::*; ();

   // Geometry and coefficient format of the instance under test (default parameters).
   localparam int MAX_W  = 1024;
   localparam int COEF_W = 20;

   // Handshake pacing: each side waits a random gap of at most GAP_MAX before every word.
   localparam int GAP_MAX  = 18;
   localparam int SENDER   = 0;
   localparam int RECEIVER = 1;

   // Row 0 pixels of a frame taller than one row leave no word, so let the pipeline
   // run dry before touching registers.
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PIXELS  = 90;
   localparam int WIDE_PIXELS    = 8;

   // Marks a directed pixel whose expected output comes from the predictor alone.
   localparam int FROM_MODEL = -1;

   typedef struct packed {
      pix_type                    pixel;
      logic [OUT_COL_BITS-1:0]    column;
      logic [IMG_HEIGHT_BITS-1:0] row;
      logic                       run_last;
      logic                       frame_end;
   } filtered_word_t;

   // One line of the directed plan: a register write or a pixel with an optional
   // typed-in value for the last word that the pixel releases.
   typedef struct {
      logic                      is_reg;
      csr_index_type             index;
      logic [CSR_DATA_WIDTH-1:0] data;
      pix_type                   pixel;
      int                        want;
   } plan_entry_t;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   c3f_req_if req_bus ();
   c3f_rsp_if rsp_bus ();

   conv3x3_image_filter_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Predictor: a private copy of the filter state, advanced once per accepted
   // pixel word. Every filtered word it computes waits in filtered_q.
   // ------------------------------------------------------------------------
   logic [COEF_ROW_WIDTH-1:0]  coef_rows [KERNEL_SIZE];
   logic [IMG_WIDTH_BITS-1:0]  img_w;
   logic [IMG_HEIGHT_BITS-1:0] img_h;
   pix_type                    line_upper [MAX_W];
   pix_type                    line_lower [MAX_W];
   pix_type                    win [KERNEL_SIZE * KERNEL_SIZE];
   int unsigned                col_cnt;
   int unsigned                row_cnt;

   filtered_word_t filtered_q [$];
   plan_entry_t    plan_q [$];

   int mismatches;
   int quiet_cycles;
   int stretch_left [2];
   bit stretch_calm [2];

   // Zero acts as one; anything above the line store depth acts as its depth.
   function automatic int unsigned eff_width(input logic [IMG_WIDTH_BITS-1:0] v);
      if (v == 0) return 1;
      return (v > MAX_W) ? MAX_W : v;
   endfunction

   function automatic int unsigned eff_height(input logic [IMG_HEIGHT_BITS-1:0] v);
      return (v == 0) ? 1 : v;
   endfunction

   // Weighted sum around window centre (cr, cc); window row 0 is image row r-2,
   // window column 0 is image column c-2. Taps off the image count as zero.
   function automatic pix_type window_result(input int unsigned cr, cc, r, c);
      longint               acc;
      int unsigned          ky, kx, wr, wc;
      logic [COEF_W-1:0]    coef;
      longint               rounded;
      acc = 0;
      for (ky = 0; ky < KERNEL_SIZE; ky++) begin
         for (kx = 0; kx < KERNEL_SIZE; kx++) begin
            wr = cr - 1 + ky;
            wc = cc - 1 + kx;
            if (wr > 2 || wc > 2) continue;
            if ((wr == 0 && r < 2) || (wr == 1 && r < 1)) continue;
            if ((wc == 0 && c < 2) || (wc == 1 && c < 1)) continue;
            coef = coef_rows[ky][kx*COEF_W +: COEF_W];
            acc += longint'(win[wr*3 + wc]) * longint'($signed(coef));
         end
      end
      // Clamp first, then round half up.
      if (acc < 0) acc = 0;
      if (acc > (longint'(PIX_MAX) << FRAC_BITS)) acc = longint'(PIX_MAX) << FRAC_BITS;
      rounded = (acc + ROUND_HALF) >>> FRAC_BITS;
      return rounded[7:0];
   endfunction

   // Shift one pixel into the window and line stores, queue the words it releases.
   task automatic advance_filter(input pix_type pix, input int want);
      int unsigned    w, h, c, r, idx, n, k, cr, cc, pos;
      bit             col_last, row_last;
      filtered_word_t words [RESULT_SLOTS];
      w = eff_width(img_w);
      h = eff_height(img_h);
      c = col_cnt;
      r = row_cnt;
      idx = (c < MAX_W) ? c : MAX_W - 1;
      // A counter already past a shrunken geometry counts as sitting on its last column/row.
      col_last = (c >= w - 1);
      row_last = (r >= h - 1);

      for (k = 0; k < KERNEL_SIZE; k++) begin
         win[k*3]     = win[k*3 + 1];
         win[k*3 + 1] = win[k*3 + 2];
      end
      win[2] = line_upper[idx];
      win[5] = line_lower[idx];
      win[8] = pix;
      line_upper[idx] = line_lower[idx];
      line_lower[idx] = pix;

      // Release rows r-1 and (on the last row) r; in each, columns c-1 and
      // (on the last column) c, in raster order.
      n = 0;
      for (cr = 1; cr <= 2; cr++) begin
         if (cr == 1 && r < 1) continue;
         if (cr == 2 && !row_last) continue;
         for (cc = 1; cc <= 2; cc++) begin
            if (cc == 1 && c < 1) continue;
            if (cc == 2 && !col_last) continue;
            words[n].pixel     = window_result(cr, cc, r, c);
            pos                = c - (2 - cc);
            words[n].column    = pos[OUT_COL_BITS-1:0];
            pos                = r - (2 - cr);
            words[n].row       = pos[IMG_HEIGHT_BITS-1:0];
            words[n].run_last  = 1'b0;
            words[n].frame_end = (cr == 2 && cc == 2);
            n++;
         end
      end
      if (n > 0) begin
         words[n-1].run_last = 1'b1;
         // A typed-in value overrides the prediction for the closing word.
         if (want != FROM_MODEL) words[n-1].pixel = want[7:0];
      end
      for (k = 0; k < n; k++) filtered_q.push_back(words[k]);

      if (col_last) begin
         col_cnt = 0;
         row_cnt = row_last ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
   endtask

   // Gap before the next word of one side; stretches of zero gaps come and go.
   function automatic int draw_gap(input int side);
      if (stretch_left[side] == 0) begin
         stretch_left[side] = $urandom_range(6, 40);
         stretch_calm[side] = ($urandom_range(0, 3) == 0);
      end
      stretch_left[side]--;
      return stretch_calm[side] ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   function automatic logic [COEF_ROW_WIDTH-1:0] kernel_row(
      input logic [COEF_W-1:0] left, centre, right);
      return {right, centre, left};
   endfunction

   // Mostly gentle coefficients (-1.0 .. +1.0), now and then any 20-bit value to push the clamp.
   function automatic logic [COEF_W-1:0] rand_coef();
      int v;
      if ($urandom_range(0, 5) == 0) return COEF_W'($urandom);
      v = int'($urandom_range(0, 8192)) - 4096;
      return v[COEF_W-1:0];
   endfunction

   function automatic logic [COEF_ROW_WIDTH-1:0] rand_kernel_row();
      return kernel_row(rand_coef(), rand_coef(), rand_coef());
   endfunction

   // Random content above the register's own bits, which the block must ignore.
   function automatic logic [CSR_DATA_WIDTH-1:0] noisy_data();
      return {28'($urandom), 32'($urandom)};
   endfunction

   function automatic pix_type rand_pixel();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void plan_reg(input csr_index_type index,
                                    input logic [CSR_DATA_WIDTH-1:0] data);
      plan_q.push_back('{1'b1, index, data, 8'd0, FROM_MODEL});
   endfunction

   function automatic void plan_pixel(input pix_type pixel, input int want);
      plan_q.push_back('{1'b0, CSR_COEF_TOP, '0, pixel, want});
   endfunction

   // ------------------------------------------------------------------------
   // Drivers. Inputs change on the falling edge; handshakes resolve on the rising one.
   // ------------------------------------------------------------------------

   // Drop valid, hold until every expected word is out plus the pipeline tail,
   // then write one register. This is also where the sender pauses for drain.
   task automatic write_reg(input csr_index_type index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (index)
         CSR_COEF_TOP:     coef_rows[0] = data;
         CSR_COEF_MID:     coef_rows[1] = data;
         CSR_COEF_BOTTOM:  coef_rows[2] = data;
         CSR_IMAGE_WIDTH:  img_w = data[IMG_WIDTH_BITS-1:0];
         CSR_IMAGE_HEIGHT: img_h = data[IMG_HEIGHT_BITS-1:0];
         default: ;
      endcase
   endtask

   // Offer one pixel word after a random gap; advance the predictor once taken.
   // Valid stays high into the next word when its gap is zero.
   task automatic send_pixel(input pix_type pixel, input int want);
      int gap;
      gap = draw_gap(SENDER);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.pixel_in <= pixel;
      do @(posedge clock); while (!req_bus.ready);
      advance_filter(pixel, want);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: stall a random number of cycles before taking each word.
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      forever begin
         gap = draw_gap(RECEIVER);
         repeat (gap) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Compare every accepted result word against the oldest prediction.
   always @(posedge clock) begin
      filtered_word_t got, due;
      if (rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.pixel_out, rsp_bus.out_column, rsp_bus.out_row,
                rsp_bus.run_last, rsp_bus.frame_end};
         if (filtered_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word: pix %0d col %0d row %0d last %0b end %0b",
                     $time, got.pixel, got.column, got.row, got.run_last, got.frame_end);
         end else begin
            due = filtered_q.pop_front();
            if (got !== due) begin
               mismatches++;
               $display("%0t: mismatch: expected pix %0d col %0d row %0d last %0b end %0b",
                        $time, due.pixel, due.column, due.row, due.run_last,
                        due.frame_end);
               $display("%0t:           actual   pix %0d col %0d row %0d last %0b end %0b",
                        $time, got.pixel, got.column, got.row, got.run_last,
                        got.frame_end);
            end
         end
      end
   end

   // Watchdog: end the run when no word and no register write moves for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, nothing moved for %0d cycles, %0d words outstanding",
                  $time, quiet_cycles, filtered_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int unsigned                w_new, h_new, rows, total, n, i;
      logic [CSR_DATA_WIDTH-1:0]  data;
      int                         random_pixels;

      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_COEF_TOP;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.pixel_in = '0;
      mismatches       = 0;
      quiet_cycles     = 0;
      random_pixels    = 0;
      stretch_left     = '{0, 0};
      stretch_calm     = '{0, 0};

      // Predictor state after reset; line stores are never read before written.
      coef_rows[0] = COEF_TOP_RESET;
      coef_rows[1] = COEF_MID_RESET;
      coef_rows[2] = COEF_BOTTOM_RESET;
      img_w        = IMG_WIDTH_RESET;
      img_h        = IMG_HEIGHT_RESET;
      foreach (line_upper[k]) line_upper[k] = '0;
      foreach (line_lower[k]) line_lower[k] = '0;
      foreach (win[k]) win[k] = '0;
      col_cnt = 0;
      row_cnt = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- Directed plan ----
      // Zero width and height act as a 1x1 frame: each pixel is its own frame and,
      // with the identity kernel from reset, comes straight back.
      plan_reg(CSR_IMAGE_WIDTH, '0);
      plan_reg(CSR_IMAGE_HEIGHT, '0);
      plan_pixel(8'd0, 0);
      plan_pixel(8'd255, 255);
      // Largest positive centre tap saturates high, most negative saturates at zero.
      plan_reg(CSR_COEF_MID, kernel_row(20'h00000, 20'h7FFFF, 20'h00000));
      plan_pixel(8'd255, 255);
      plan_reg(CSR_COEF_MID, kernel_row(20'h00000, 20'h80000, 20'h00000));
      plan_pixel(8'd255, 0);
      // Centre tap of one half: exact ties round up.
      plan_reg(CSR_COEF_MID, kernel_row(20'h00000, 20'h00800, 20'h00000));
      plan_pixel(8'd1, 1);
      plan_pixel(8'd3, 2);
      // Full 3x3 frame with a mixed-sign kernel: every border case, and the
      // bottom-right pixel releasing four words.
      plan_reg(CSR_COEF_TOP,    kernel_row(20'h01000, 20'hFF000, 20'h00800));
      plan_reg(CSR_COEF_MID,    kernel_row(20'h00400, 20'h02000, 20'hFFC00));
      plan_reg(CSR_COEF_BOTTOM, kernel_row(20'h00C00, 20'h00100, 20'hFF800));
      plan_reg(CSR_IMAGE_WIDTH, 60'd3);
      plan_reg(CSR_IMAGE_HEIGHT, 60'd3);
      plan_pixel(8'd0, FROM_MODEL);
      plan_pixel(8'd255, FROM_MODEL);
      plan_pixel(8'd17, FROM_MODEL);
      plan_pixel(8'd128, FROM_MODEL);
      plan_pixel(8'd64, FROM_MODEL);
      plan_pixel(8'd200, FROM_MODEL);
      plan_pixel(8'd255, FROM_MODEL);
      plan_pixel(8'd1, FROM_MODEL);
      plan_pixel(8'd90, FROM_MODEL);
      // Geometry changed mid-frame: tallest height, widen while still on row 0,
      // then narrow below the counter (wraps the row) and cut the height below
      // the current row (ends the frame).
      plan_reg(CSR_IMAGE_HEIGHT, 60'hFFFF);
      plan_pixel(8'd10, FROM_MODEL);
      plan_pixel(8'd250, FROM_MODEL);
      plan_reg(CSR_IMAGE_WIDTH, 60'd4);
      plan_pixel(8'd33, FROM_MODEL);
      plan_pixel(8'd77, FROM_MODEL);
      plan_pixel(8'd5, FROM_MODEL);
      plan_pixel(8'd160, FROM_MODEL);
      plan_pixel(8'd240, FROM_MODEL);
      plan_reg(CSR_IMAGE_WIDTH, 60'd2);
      plan_pixel(8'd99, FROM_MODEL);
      plan_reg(CSR_IMAGE_HEIGHT, 60'd2);
      plan_pixel(8'd44, FROM_MODEL);
      plan_pixel(8'd180, FROM_MODEL);

      foreach (plan_q[k]) begin
         if (plan_q[k].is_reg)
            write_reg(plan_q[k].index, plan_q[k].data);
         else
            send_pixel(plan_q[k].pixel, plan_q[k].want);
      end

      // ---- Wide single-row frame ----
      // Width above the line store depth acts as the depth: a short run along
      // row 0, with junk above each register's own bits.
      data = noisy_data();
      data[IMG_WIDTH_BITS-1:0] = '1;
      write_reg(CSR_IMAGE_WIDTH, data);
      data = noisy_data();
      data[IMG_HEIGHT_BITS-1:0] = 16'd1;
      write_reg(CSR_IMAGE_HEIGHT, data);
      write_reg(CSR_COEF_TOP, rand_kernel_row());
      write_reg(CSR_COEF_MID, rand_kernel_row());
      write_reg(CSR_COEF_BOTTOM, rand_kernel_row());
      for (i = 0; i < WIDE_PIXELS; i++) send_pixel(rand_pixel(), FROM_MODEL);

      // ---- Random frames ----
      // Mostly whole small frames; about one phase in four breaks off mid-frame,
      // so the next geometry write lands on a busy counter.
      while (random_pixels < RANDOM_PIXELS) begin
         w_new = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
         h_new = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
         if ($urandom_range(0, 9) == 0) h_new = 32'h0000_FFFF;
         // Past row 0, keep the width from growing: wider columns of the rows
         // above were never stored in this frame.
         if (row_cnt != 0 && eff_width(IMG_WIDTH_BITS'(w_new)) > eff_width(img_w))
            w_new = {21'd0, img_w};

         data = noisy_data();
         data[IMG_WIDTH_BITS-1:0] = IMG_WIDTH_BITS'(w_new);
         write_reg(CSR_IMAGE_WIDTH, data);
         data = noisy_data();
         data[IMG_HEIGHT_BITS-1:0] = IMG_HEIGHT_BITS'(h_new);
         write_reg(CSR_IMAGE_HEIGHT, data);
         if ($urandom_range(0, 1) == 1) begin
            write_reg(CSR_COEF_TOP, rand_kernel_row());
            write_reg(CSR_COEF_MID, rand_kernel_row());
            write_reg(CSR_COEF_BOTTOM, rand_kernel_row());
         end

         rows = (eff_height(img_h) > 8) ? $urandom_range(1, 8)
                                        : eff_height(img_h) * $urandom_range(1, 2);
         total = rows * eff_width(img_w);
         if ($urandom_range(0, 3) == 0) total = $urandom_range(1, total);
         // Stay within the pixel budget; the last phase may stop mid-frame.
         if (total > $unsigned(RANDOM_PIXELS - random_pixels))
            total = $unsigned(RANDOM_PIXELS - random_pixels);
         for (n = 0; n < total; n++) begin
            send_pixel(rand_pixel(), FROM_MODEL);
            random_pixels++;
         end
      end

      // ---- Drain ----
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
